### rtl/core/adcscan_pkg.sv
package adcscan_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_ADDR_W-1:0] REG_REFERENCE_MV = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BATTERY_RATIO = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RAIL_RATIO = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_OFFSET = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_SLOPE = 3'd4;

    localparam int REF_MV_W = 11;
    localparam int BAT_RATIO_W = 4;
    localparam int RAIL_RATIO_W = 5;
    localparam int OFFSET_W = 11;
    localparam int SLOPE_W = 14;

    localparam logic [REF_MV_W-1:0] REF_MV_RST = 11'd1200;
    localparam logic [BAT_RATIO_W-1:0] BAT_RATIO_RST = 4'd4;
    localparam logic [RAIL_RATIO_W-1:0] RAIL_RATIO_RST = 5'd11;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 11'd750;
    localparam logic [SLOPE_W-1:0] SLOPE_RST = 14'd2750;

    // channels and scan phases (phase n works on channel n-1)
    localparam int CH_W = 3;
    localparam int CH_COUNT = 5;
    localparam logic [CH_W-1:0] CH_REF = 3'd0;
    localparam logic [CH_W-1:0] CH_BAT = 3'd1;
    localparam logic [CH_W-1:0] CH_RAIL8 = 3'd2;
    localparam logic [CH_W-1:0] CH_RAIL12 = 3'd3;
    localparam logic [CH_W-1:0] CH_TEMP = 3'd4;

    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PH_W-1:0] PH_FIRST = 3'd1;
    localparam logic [PH_W-1:0] PH_LAST = 3'd5;
    localparam int PH_COUNT = 6;

    // result formats
    localparam int MV_W = 16;
    localparam int TEMP_W = 16;
    localparam logic [MV_W-1:0] VOLT_MAX = 16'hFFFF;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 16'h7FFF;
    localparam logic [TEMP_W-1:0] TEMP_MIN = 16'h8000;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    // m_tdata and m_tuser layout
    localparam int OUT_START_BIT = 0;
    localparam int OUT_CHAN_LSB = 1;
    localparam int OUT_BAT_LSB = 4;
    localparam int OUT_ZERO_BIT = 68;
    localparam int OUT_SEL_BIT = 0;
    localparam int OUT_REP_BIT = 1;

    // arithmetic
    localparam int QUO_BITS = 17;
    localparam int DIV_CNT_W = 5;
    localparam int SCALE_W = 17;
    localparam logic [SCALE_W-1:0] TEMP_SCALE = 17'd100000;
    localparam logic [QUO_BITS-1:0] TEMP_CAP = 17'd100000;
    localparam int TEMP_BIAS = 2500;

    // microcode
    typedef enum logic [3:0] {
        OP_CHKZ,
        OP_MUL,
        OP_LDV,
        OP_LDDEN,
        OP_LDT1,
        OP_DIFF,
        OP_LDTN,
        OP_DIV,
        OP_STV,
        OP_STT,
        OP_END
    } uop_t;

    typedef enum logic [2:0] {
        A_RAW_BAT,
        A_RAW_R8,
        A_RAW_R12,
        A_RAW_T,
        A_REF,
        A_PROD,
        A_MAG
    } asel_t;

    typedef enum logic [2:0] {
        B_BAT,
        B_RAIL,
        B_VREF,
        B_OFFSET,
        B_SLOPE,
        B_SCALE
    } bsel_t;

    typedef enum logic [1:0] {
        D_BAT,
        D_R8,
        D_R12
    } dst_t;

    localparam int PC_W = 5;
    localparam int PROG_LEN = 27;
    localparam logic [PC_W-1:0] NO_JUMP = 5'd0;
    localparam logic [PC_W-1:0] PC_END = 5'd26;

    typedef struct packed {
        uop_t op;
        asel_t asel;
        bsel_t bsel;
        dst_t dst;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam ucode_t UCODE [PROG_LEN] = '{
        '{OP_CHKZ, A_REF,     B_VREF,   D_BAT, PC_END},   // zero reference: skip to end
        '{OP_MUL,  A_RAW_BAT, B_BAT,    D_BAT, NO_JUMP},
        '{OP_MUL,  A_PROD,    B_VREF,   D_BAT, NO_JUMP},
        '{OP_LDV,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_DIV,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_STV,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_MUL,  A_RAW_R8,  B_RAIL,   D_BAT, NO_JUMP},
        '{OP_MUL,  A_PROD,    B_VREF,   D_BAT, NO_JUMP},
        '{OP_LDV,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_DIV,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_STV,  A_REF,     B_VREF,   D_R8,  NO_JUMP},
        '{OP_MUL,  A_RAW_R12, B_RAIL,   D_BAT, NO_JUMP},
        '{OP_MUL,  A_PROD,    B_VREF,   D_BAT, NO_JUMP},
        '{OP_LDV,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_DIV,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_STV,  A_REF,     B_VREF,   D_R12, NO_JUMP},
        '{OP_MUL,  A_REF,     B_SLOPE,  D_BAT, NO_JUMP},
        '{OP_LDDEN, A_REF,    B_VREF,   D_BAT, NO_JUMP},
        '{OP_MUL,  A_RAW_T,   B_VREF,   D_BAT, NO_JUMP},
        '{OP_LDT1, A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_MUL,  A_REF,     B_OFFSET, D_BAT, NO_JUMP},
        '{OP_DIFF, A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_MUL,  A_MAG,     B_SCALE,  D_BAT, NO_JUMP},
        '{OP_LDTN, A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_DIV,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_STT,  A_REF,     B_VREF,   D_BAT, NO_JUMP},
        '{OP_END,  A_REF,     B_VREF,   D_BAT, NO_JUMP}
    };

endpackage

### rtl/core/adc_channel_scan_vref_ratiometric.sv
// Five-channel converter scan sequencer. One input word arrives per millisecond tick and
// produces exactly one output word. The scan order is reference, battery, 8 V rail, 12 V rail,
// temperature: after each channel selection the next word asks for a conversion, later words
// wait for conversion_done, store the sample and select the next channel. When the temperature
// sample is stored the output word also carries the battery and rail voltages in mV and the
// temperature in hundredths of a degree, all computed as ratios against the reference sample
// and saturated; a zero reference sample reports full scale and sets reference_zero.
// An ordinary word holds off new words until the output register is free. The word that
// closes a scan first runs a 27-step microprogram over one shared multiplier and a 17-step
// restoring divider, used four times; an overflowing quotient saturates at once and a zero
// reference sample skips to the end. The output register is separate from the input side, so
// a new word is accepted while a finished result still waits for m_tready. Configuration must
// be written through cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
module adc_channel_scan_vref_ratiometric #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration writes
    input  logic                                   cfg_we,
    input  logic [adcscan_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [adcscan_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input words
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample_value
    input  logic                                   s_tuser,   // conversion_done
    // output words
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // start_conversion, channel, battery_mv, rail8_mv, rail12_mv, temp_centideg,
    // reference_zero, zero fill
    output logic [adcscan_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [adcscan_pkg::OUT_USER_W-1:0]     m_tuser    // select_channel, report_valid
);
    import adcscan_pkg::*;

    // datapath widths; all but operand b and the temperature sum follow the sample width
    localparam int S_W = SAMPLE_BITS;
    localparam int MA_W = S_W + 11;            // multiplier operand a
    localparam int MB_W = SCALE_W;             // multiplier operand b
    localparam int P_W = MA_W + MB_W;          // product
    localparam int MAG_W = S_W + 11;           // temperature difference magnitude
    localparam int DV_W = S_W + 29;            // dividend
    localparam int DS_W = S_W + 15;            // divisor
    localparam int T_W = QUO_BITS + 2;         // signed temperature sum

    localparam logic signed [T_W-1:0] T_BIAS_S = T_W'(TEMP_BIAS);
    localparam logic signed [T_W-1:0] T_MAX_S = T_W'(32767);
    localparam logic signed [T_W-1:0] T_MIN_S = T_W'(-32768);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // control state
    state_t                   state_reg, state_next;
    logic [PH_W-1:0]          phase_reg, phase_next;
    logic                     await_reg, await_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic                     div_act_reg, div_act_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // configuration
    logic [REF_MV_W-1:0]      ref_mv_reg, ref_mv_next;
    logic [BAT_RATIO_W-1:0]   bat_ratio_reg, bat_ratio_next;
    logic [RAIL_RATIO_W-1:0]  rail_ratio_reg, rail_ratio_next;
    logic [OFFSET_W-1:0]      offset_reg, offset_next;
    logic [SLOPE_W-1:0]       slope_reg, slope_next;

    // sample store, one entry per channel, no reset
    logic [S_W-1:0]           raw_mem [CH_COUNT];
    logic                     raw_we;
    logic [CH_W-1:0]          raw_idx;

    // datapath
    logic [P_W-1:0]           prod_reg, prod_next;
    logic [MAG_W-1:0]         t1_reg, t1_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [DV_W-1:0]          num_reg, num_next;
    logic [DS_W-1:0]          den_reg, den_next;
    logic [DS_W-1:0]          rem_reg, rem_next;
    logic [QUO_BITS-1:0]      quo_reg, quo_next;
    logic [MV_W-1:0]          bat_reg, bat_next;
    logic [MV_W-1:0]          r8_reg, r8_next;
    logic [MV_W-1:0]          r12_reg, r12_next;
    logic [TEMP_W-1:0]        temp_reg, temp_next;
    logic                     zero_reg, zero_next;

    // pending result of the current word
    logic                     p_start_reg, p_start_next;
    logic                     p_sel_reg, p_sel_next;
    logic [CH_W-1:0]          p_chan_reg, p_chan_next;
    logic                     p_rep_reg, p_rep_next;

    logic [OUT_DATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [OUT_USER_W-1:0]    m_tuser_reg, m_tuser_next;

    // combinational helpers
    ucode_t                   uw;
    logic                     s_accept;
    logic                     out_free;
    logic                     out_load;
    logic [S_W-1:0]           sample;
    logic [S_W-1:0]           refv;
    logic                     phase_valid;
    logic [PH_W:0]            phase_inc;
    logic [PH_W-1:0]          phase_succ;
    logic [SLOPE_W-1:0]       slope_eff;
    logic [MA_W-1:0]          mul_a;
    logic [MB_W-1:0]          mul_b;
    logic [P_W-1:0]           product;
    logic                     div_ovf;
    logic [DS_W:0]            div_trial;
    logic                     div_ge;
    logic [DS_W-1:0]          div_rem;
    logic [MV_W-1:0]          volt_sat;
    logic [QUO_BITS-1:0]      temp_q;
    logic signed [T_W-1:0]    temp_qs;
    logic signed [T_W-1:0]    temp_sum;
    logic [TEMP_W-1:0]        temp_sat;

    assign uw = UCODE[pc_reg];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_HOLD) && out_free;
    assign sample = s_tdata[S_W-1:0];
    assign refv = raw_mem[CH_REF];
    assign slope_eff = (slope_reg == '0) ? SLOPE_W'(1) : slope_reg;

    // next phase: (phase + 1) mod 6, never idle
    assign phase_valid = (phase_reg >= PH_FIRST) && (phase_reg <= PH_LAST);
    always_comb
    begin
        phase_inc = {1'b0, phase_reg} + (PH_W+1)'(1);
        if (phase_inc >= (PH_W+1)'(PH_COUNT))
        begin
            phase_inc = phase_inc - (PH_W+1)'(PH_COUNT);
        end
        if (phase_inc == '0)
        begin
            phase_inc = (PH_W+1)'(PH_FIRST);
        end
        phase_succ = phase_inc[PH_W-1:0];
    end

    // shared multiplier operands
    always_comb
    begin
        case (uw.asel)
            A_RAW_BAT: mul_a = MA_W'(raw_mem[CH_BAT]);
            A_RAW_R8:  mul_a = MA_W'(raw_mem[CH_RAIL8]);
            A_RAW_R12: mul_a = MA_W'(raw_mem[CH_RAIL12]);
            A_RAW_T:   mul_a = MA_W'(raw_mem[CH_TEMP]);
            A_REF:     mul_a = MA_W'(refv);
            A_PROD:    mul_a = prod_reg[MA_W-1:0];
            A_MAG:     mul_a = mag_reg;
            default:   mul_a = '0;
        endcase
        case (uw.bsel)
            B_BAT:    mul_b = MB_W'(bat_ratio_reg);
            B_RAIL:   mul_b = MB_W'(rail_ratio_reg);
            B_VREF:   mul_b = MB_W'(ref_mv_reg);
            B_OFFSET: mul_b = MB_W'(offset_reg);
            B_SLOPE:  mul_b = MB_W'(slope_eff);
            B_SCALE:  mul_b = TEMP_SCALE;
            default:  mul_b = '0;
        endcase
    end
    assign product = mul_a * mul_b;

    // restoring divider, one quotient bit per cycle
    assign div_ovf = DS_W'(num_reg[DV_W-1:QUO_BITS]) >= den_reg;
    assign div_trial = {rem_reg, num_reg[QUO_BITS-1]};
    assign div_ge = div_trial >= {1'b0, den_reg};
    assign div_rem = div_ge ? DS_W'(div_trial - {1'b0, den_reg}) : div_trial[DS_W-1:0];

    // result saturation
    assign volt_sat = quo_reg[QUO_BITS-1] ? VOLT_MAX : quo_reg[MV_W-1:0];
    assign temp_q = (quo_reg > TEMP_CAP) ? TEMP_CAP : quo_reg;
    assign temp_qs = T_W'(temp_q);
    assign temp_sum = neg_reg ? (T_BIAS_S - temp_qs) : (T_BIAS_S + temp_qs);
    always_comb
    begin
        if (temp_sum > T_MAX_S)
        begin
            temp_sat = TEMP_MAX;
        end
        else if (temp_sum < T_MIN_S)
        begin
            temp_sat = TEMP_MIN;
        end
        else
        begin
            temp_sat = temp_sum[TEMP_W-1:0];
        end
    end

    // next-state logic: configuration writes, tick handling, microcode engine, output register
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        await_next = await_reg;
        pc_next = pc_reg;
        div_act_next = div_act_reg;
        div_cnt_next = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        ref_mv_next = ref_mv_reg;
        bat_ratio_next = bat_ratio_reg;
        rail_ratio_next = rail_ratio_reg;
        offset_next = offset_reg;
        slope_next = slope_reg;
        raw_we = 1'b0;
        raw_idx = CH_W'(phase_reg - PH_FIRST);
        prod_next = prod_reg;
        t1_next = t1_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        bat_next = bat_reg;
        r8_next = r8_reg;
        r12_next = r12_reg;
        temp_next = temp_reg;
        zero_next = zero_reg;
        p_start_next = p_start_reg;
        p_sel_next = p_sel_reg;
        p_chan_next = p_chan_reg;
        p_rep_next = p_rep_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_REFERENCE_MV:  ref_mv_next = cfg_wdata[REF_MV_W-1:0];
                REG_BATTERY_RATIO: bat_ratio_next = cfg_wdata[BAT_RATIO_W-1:0];
                REG_RAIL_RATIO:    rail_ratio_next = cfg_wdata[RAIL_RATIO_W-1:0];
                REG_SENSOR_OFFSET: offset_next = cfg_wdata[OFFSET_W-1:0];
                REG_SENSOR_SLOPE:  slope_next = cfg_wdata[SLOPE_W-1:0];
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    p_start_next = 1'b0;
                    p_sel_next = 1'b0;
                    p_chan_next = CH_REF;
                    p_rep_next = 1'b0;
                    state_next = ST_HOLD;
                    if (await_reg)
                    begin
                        // start word for the channel just selected
                        await_next = 1'b0;
                        p_start_next = 1'b1;
                        p_chan_next = phase_valid ? CH_W'(phase_reg - PH_FIRST) : CH_REF;
                    end
                    else if ((phase_reg != PH_IDLE) && !s_tuser)
                    begin
                        // still converting: all-zero word
                    end
                    else
                    begin
                        raw_we = phase_valid;
                        phase_next = phase_succ;
                        await_next = 1'b1;
                        p_sel_next = 1'b1;
                        p_chan_next = CH_W'(phase_succ - PH_FIRST);
                        if (phase_reg == PH_LAST)
                        begin
                            p_rep_next = 1'b1;
                            pc_next = '0;
                            state_next = ST_RUN;
                        end
                    end
                end
            end

            ST_RUN:
            begin
                case (uw.op)
                    OP_CHKZ:
                    begin
                        if (refv == '0)
                        begin
                            zero_next = 1'b1;
                            bat_next = VOLT_MAX;
                            r8_next = VOLT_MAX;
                            r12_next = VOLT_MAX;
                            temp_next = TEMP_MAX;
                            pc_next = uw.target;
                        end
                        else
                        begin
                            zero_next = 1'b0;
                            pc_next = pc_reg + PC_W'(1);
                        end
                    end
                    OP_MUL:
                    begin
                        prod_next = product;
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_LDV:
                    begin
                        // round half up: (n + r/2) / r
                        num_next = DV_W'(prod_reg) + DV_W'(refv >> 1);
                        den_next = DS_W'(refv);
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_LDDEN:
                    begin
                        den_next = {prod_reg[DS_W-2:0], 1'b0};
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_LDT1:
                    begin
                        t1_next = prod_reg[MAG_W-1:0];
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_DIFF:
                    begin
                        if (t1_reg < prod_reg[MAG_W-1:0])
                        begin
                            neg_next = 1'b1;
                            mag_next = prod_reg[MAG_W-1:0] - t1_reg;
                        end
                        else
                        begin
                            neg_next = 1'b0;
                            mag_next = t1_reg - prod_reg[MAG_W-1:0];
                        end
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_LDTN:
                    begin
                        // (2m + d) / 2d rounds m/d half away from zero on the magnitude
                        num_next = {prod_reg[DV_W-2:0], 1'b0} + DV_W'(den_reg >> 1);
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_DIV:
                    begin
                        if (!div_act_reg)
                        begin
                            if (div_ovf)
                            begin
                                quo_next = '1;
                                pc_next = pc_reg + PC_W'(1);
                            end
                            else
                            begin
                                rem_next = DS_W'(num_reg[DV_W-1:QUO_BITS]);
                                quo_next = '0;
                                div_act_next = 1'b1;
                                div_cnt_next = DIV_CNT_W'(QUO_BITS);
                            end
                        end
                        else
                        begin
                            rem_next = div_rem;
                            quo_next = {quo_reg[QUO_BITS-2:0], div_ge};
                            num_next = num_reg << 1;
                            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                            if (div_cnt_reg == DIV_CNT_W'(1))
                            begin
                                div_act_next = 1'b0;
                                pc_next = pc_reg + PC_W'(1);
                            end
                        end
                    end
                    OP_STV:
                    begin
                        case (uw.dst)
                            D_BAT:   bat_next = volt_sat;
                            D_R8:    r8_next = volt_sat;
                            D_R12:   r12_next = volt_sat;
                            default: ;
                        endcase
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_STT:
                    begin
                        temp_next = temp_sat;
                        pc_next = pc_reg + PC_W'(1);
                    end
                    OP_END:
                    begin
                        state_next = ST_HOLD;
                    end
                    default:
                    begin
                        state_next = ST_HOLD;
                    end
                endcase
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next = OUT_DATA_W'({
                p_rep_reg & zero_reg,
                p_rep_reg ? temp_reg : '0,
                p_rep_reg ? r12_reg : '0,
                p_rep_reg ? r8_reg : '0,
                p_rep_reg ? bat_reg : '0,
                p_chan_reg,
                p_start_reg
            });
            m_tuser_next = {p_rep_reg, p_sel_reg};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            await_reg <= 1'b0;
            pc_reg <= '0;
            div_act_reg <= 1'b0;
            div_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
            ref_mv_reg <= REF_MV_RST;
            bat_ratio_reg <= BAT_RATIO_RST;
            rail_ratio_reg <= RAIL_RATIO_RST;
            offset_reg <= OFFSET_RST;
            slope_reg <= SLOPE_RST;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            await_reg <= await_next;
            pc_reg <= pc_next;
            div_act_reg <= div_act_next;
            div_cnt_reg <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            ref_mv_reg <= ref_mv_next;
            bat_ratio_reg <= bat_ratio_next;
            rail_ratio_reg <= rail_ratio_next;
            offset_reg <= offset_next;
            slope_reg <= slope_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (raw_we)
        begin
            raw_mem[raw_idx] <= sample;
        end
        prod_reg <= prod_next;
        t1_reg <= t1_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bat_reg <= bat_next;
        r8_reg <= r8_next;
        r12_reg <= r12_next;
        temp_reg <= temp_next;
        zero_reg <= zero_next;
        p_start_reg <= p_start_next;
        p_sel_reg <= p_sel_next;
        p_chan_reg <= p_chan_next;
        p_rep_reg <= p_rep_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // a report always comes with the selection of the reference channel
    a_report_selects_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[OUT_REP_BIT]) |->
        (m_tuser[OUT_SEL_BIT] && (m_tdata[OUT_CHAN_LSB +: CH_W] == CH_REF)))
        else $error("report word without reference channel selection");

    // a word never both starts a conversion and selects a channel
    a_start_or_select: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OUT_START_BIT] && m_tuser[OUT_SEL_BIT]))
        else $error("start and select in the same word");

    // the divider only iterates under a divide step of the running program
    a_div_in_div_step: assert property (@(posedge clk) disable iff (!rst_n)
        div_act_reg |-> ((state_reg == ST_RUN) && (uw.op == OP_DIV)))
        else $error("divider active outside a divide step");

    // zero reference forces saturated voltages in a report
    a_zero_ref_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[OUT_ZERO_BIT]) |->
        (m_tuser[OUT_REP_BIT] && (m_tdata[OUT_BAT_LSB +: MV_W] == VOLT_MAX)))
        else $error("reference_zero without saturated report");

endmodule

### verif/testbench.sv
module testbench;
    import adcscan_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int IN_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
    // longer than the longest scan-close word takes, leaving some margin
    localparam int SETTLE_CYCLES = 120;
    localparam int WORDS_PER_SETTING = 130;

    // one output word, unpacked into its fields
    typedef struct packed {
        logic             start_conv;
        logic             select_ch;
        logic [CH_W-1:0]  chan;
        logic             report;
        logic [MV_W-1:0]  battery;
        logic [MV_W-1:0]  rail8;
        logic [MV_W-1:0]  rail12;
        logic [TEMP_W-1:0] temp;
        logic             ref_zero;
    } scan_word_t;

    // receiver back-pressure styles
    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_COMB,
        RX_LONG
    } rx_mode_t;

    // tracks the scan sequencer and holds the words it must emit, oldest first
    class scan_scoreboard;
        logic [REF_MV_W-1:0]     ref_mv;
        logic [BAT_RATIO_W-1:0]  bat_ratio;
        logic [RAIL_RATIO_W-1:0] rail_ratio;
        logic [OFFSET_W-1:0]     offset_mv;
        logic [SLOPE_W-1:0]      slope_uv;

        logic [PH_W-1:0]         phase;
        bit                      awaiting_start;
        logic [SAMPLE_BITS-1:0]  raw_samples [CH_COUNT];

        scan_word_t              words_due [$];
        int                      errors;
        int                      n_words;
        int                      n_reports;
        int                      n_zero_ref;
        int                      n_saturated;

        function new();
            ref_mv = REF_MV_RST;
            bat_ratio = BAT_RATIO_RST;
            rail_ratio = RAIL_RATIO_RST;
            offset_mv = OFFSET_RST;
            slope_uv = SLOPE_RST;
            phase = PH_IDLE;
            awaiting_start = 1'b0;
            foreach (raw_samples[i])
                raw_samples[i] = '0;
            errors = 0;
            n_words = 0;
            n_reports = 0;
            n_zero_ref = 0;
            n_saturated = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_REFERENCE_MV:  ref_mv = data[REF_MV_W-1:0];
                REG_BATTERY_RATIO: bat_ratio = data[BAT_RATIO_W-1:0];
                REG_RAIL_RATIO:    rail_ratio = data[RAIL_RATIO_W-1:0];
                REG_SENSOR_OFFSET: offset_mv = data[OFFSET_W-1:0];
                REG_SENSOR_SLOPE:  slope_uv = data[SLOPE_W-1:0];
                default: ;
            endcase
        endfunction

        // raw * factor * vref / refs, halves rounded up, saturated
        function logic [MV_W-1:0] scaled_mv(longint unsigned raw, longint unsigned factor,
                                            longint unsigned refs);
            longint unsigned q;
            q = (raw * factor * ref_mv + refs / 2) / refs;
            if (q > VOLT_MAX)
                q = VOLT_MAX;
            return MV_W'(q);
        endfunction

        // sensor voltage against offset and slope, halves away from zero
        function logic [TEMP_W-1:0] centideg(longint unsigned raw_t, longint unsigned refs);
            longint unsigned slope;
            longint unsigned den;
            longint unsigned mag;
            longint unsigned q;
            longint num;
            longint t;
            slope = (slope_uv == 0) ? 1 : slope_uv;
            num = (longint'(raw_t * ref_mv) - longint'(refs * offset_mv)) * 100000;
            den = refs * slope;
            mag = (num < 0) ? -num : num;
            q = (mag * 2 + den) / (den * 2);
            if (q > 100000)
                q = 100000;
            t = (num < 0) ? -longint'(q) : longint'(q);
            t = t + TEMP_BIAS;
            if (t > 32767)
                t = 32767;
            if (t < -32768)
                t = -32768;
            return TEMP_W'(t);
        endfunction

        function void note_word(logic done, logic [SAMPLE_BITS-1:0] sample);
            scan_word_t w;
            logic [PH_W-1:0] nxt;
            longint unsigned refs;
            w = '0;
            n_words++;
            // start tick: input ignored
            if (awaiting_start) begin
                awaiting_start = 1'b0;
                w.start_conv = 1'b1;
                w.chan = (phase >= PH_FIRST && phase <= PH_LAST) ? CH_W'(phase - PH_FIRST)
                                                                 : CH_REF;
                words_due.push_back(w);
                return;
            end
            if (phase != PH_IDLE) begin
                // still converting
                if (!done) begin
                    words_due.push_back(w);
                    return;
                end
                if (phase <= PH_LAST)
                    raw_samples[phase - PH_FIRST] = sample;
            end
            if (phase == PH_LAST) begin
                refs = raw_samples[CH_REF];
                w.report = 1'b1;
                n_reports++;
                if (refs == 0) begin
                    w.battery = VOLT_MAX;
                    w.rail8 = VOLT_MAX;
                    w.rail12 = VOLT_MAX;
                    w.temp = TEMP_MAX;
                    w.ref_zero = 1'b1;
                    n_zero_ref++;
                end
                else begin
                    w.battery = scaled_mv(raw_samples[CH_BAT], bat_ratio, refs);
                    w.rail8 = scaled_mv(raw_samples[CH_RAIL8], rail_ratio, refs);
                    w.rail12 = scaled_mv(raw_samples[CH_RAIL12], rail_ratio, refs);
                    w.temp = centideg(raw_samples[CH_TEMP], refs);
                    if (w.battery == VOLT_MAX || w.rail8 == VOLT_MAX || w.rail12 == VOLT_MAX
                        || w.temp == TEMP_MAX || w.temp == TEMP_MIN)
                        n_saturated++;
                end
            end
            nxt = PH_W'((int'(phase) + 1) % PH_COUNT);
            if (nxt < PH_FIRST)
                nxt = PH_FIRST;
            phase = nxt;
            awaiting_start = 1'b1;
            w.select_ch = 1'b1;
            w.chan = CH_W'(nxt - PH_FIRST);
            words_due.push_back(w);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] tdata, logic [OUT_USER_W-1:0] tuser);
            scan_word_t want;
            scan_word_t got;
            got.start_conv = tdata[OUT_START_BIT];
            got.chan = tdata[OUT_CHAN_LSB +: CH_W];
            got.battery = tdata[OUT_BAT_LSB +: MV_W];
            got.rail8 = tdata[OUT_BAT_LSB + MV_W +: MV_W];
            got.rail12 = tdata[OUT_BAT_LSB + 2 * MV_W +: MV_W];
            got.temp = tdata[OUT_BAT_LSB + 3 * MV_W +: TEMP_W];
            got.ref_zero = tdata[OUT_ZERO_BIT];
            got.select_ch = tuser[OUT_SEL_BIT];
            got.report = tuser[OUT_REP_BIT];
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual tdata %h tuser %h",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = words_due.pop_front();
            compare("start_conversion", want.start_conv, got.start_conv);
            compare("select_channel", want.select_ch, got.select_ch);
            compare("channel", want.chan, got.chan);
            compare("report_valid", want.report, got.report);
            compare("battery_mv", want.battery, got.battery);
            compare("rail8_mv", want.rail8, got.rail8);
            compare("rail12_mv", want.rail12, got.rail12);
            compare("temp_centideg", want.temp, got.temp);
            compare("reference_zero", want.ref_zero, got.ref_zero);
            compare("zero fill", '0, tdata[OUT_DATA_W-1:OUT_ZERO_BIT+1]);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_W-1:0]         s_tdata = '0;   // sample_value, zero fill
    logic                    s_tuser = 1'b0; // conversion_done
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // start_conversion, channel, battery_mv, rail8_mv, rail12_mv, temp_centideg,
    // reference_zero, zero fill
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [OUT_USER_W-1:0]   m_tuser;        // select_channel, report_valid

    scan_scoreboard sb;

    // sender burst shaping and receiver stall style, changed per register setting
    int       burst_left;
    int       gap_max;
    rx_mode_t rx_mode = RX_OPEN;
    int       n_settings = 0;

    always #10 clk = ~clk;

    adc_channel_scan_vref_ratiometric #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // register write; bits above the register width carry random junk
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value,
                             input int width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value)
             | (CFG_DATA_W'($urandom) & ~((CFG_DATA_W'(1) << width) - CFG_DATA_W'(1)));
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    // present one word, hold it until taken, then maybe open a gap
    task automatic send_word(input logic done, input logic [SAMPLE_BITS-1:0] sample);
        s_tvalid <= 1'b1;
        s_tdata <= IN_W'(sample);
        s_tuser <= done;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(done, sample);
        burst_left--;
        if (burst_left <= 0) begin
            if (gap_max > 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max))
                    @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // hold off the sender until every predicted word has come out
    task automatic drain_words();
        s_tvalid <= 1'b0;
        while (sb.words_due.size() != 0)
            @(posedge clk);
    endtask

    // sample suited to the channel being converted
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [PH_W-1:0] ch;
        longint centre;
        if (sb.awaiting_start || sb.phase == PH_IDLE || sb.phase > PH_LAST)
            return SAMPLE_BITS'($urandom);
        ch = sb.phase - PH_FIRST;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FULL_SCALE;
            default: ;
        endcase
        if (ch == CH_REF) begin
            // tiny reference drives the voltages into saturation
            if ($urandom_range(0, 7) == 0)
                return SAMPLE_BITS'($urandom_range(1, 8));
            if ($urandom_range(0, 1) != 0)
                return SAMPLE_BITS'($urandom_range(1300, 1700));
        end
        if (ch == CH_TEMP && sb.raw_samples[CH_REF] != 0 && $urandom_range(0, 1) != 0) begin
            // near the 25 degree point so the result stays out of saturation
            centre = longint'(sb.raw_samples[CH_REF]) * sb.offset_mv / sb.ref_mv;
            centre = centre + int'($urandom_range(0, 400)) - 200;
            if (centre < 0)
                centre = 0;
            if (centre > FULL_SCALE)
                centre = FULL_SCALE;
            return SAMPLE_BITS'(centre);
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    // one register setting followed by a stretch of random scan traffic
    task automatic run_setting(input int unsigned ref_v, input int unsigned bat_v,
                               input int unsigned rail_v, input int unsigned off_v,
                               input int unsigned slope_v, input int gaps,
                               input rx_mode_t rx, input int n_items);
        int done_odds;
        drain_words();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        write_reg(REG_REFERENCE_MV, ref_v, REF_MV_W);
        write_reg(REG_BATTERY_RATIO, bat_v, BAT_RATIO_W);
        write_reg(REG_RAIL_RATIO, rail_v, RAIL_RATIO_W);
        write_reg(REG_SENSOR_OFFSET, off_v, OFFSET_W);
        write_reg(REG_SENSOR_SLOPE, slope_v, SLOPE_W);
        // unmapped index, must leave every register alone
        write_reg(CFG_ADDR_W'(REG_SENSOR_SLOPE + 1 + $urandom_range(0, 2)), 0, 0);
        cfg_we <= 1'b0;
        n_settings++;
        gap_max = gaps;
        rx_mode = rx;
        burst_left = $urandom_range(1, 16);
        // how often the converter is still busy
        done_odds = $urandom_range(1, 4);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2)
                drain_words();
            send_word($urandom_range(0, done_odds) != 0, pick_sample());
        end
    endtask

    // receiver: check what is taken, then pick the next ready level
    initial begin
        int rx_cycle;
        int hold;
        logic level;
        rx_cycle = 0;
        hold = 0;
        level = 1'b1;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tuser);
            rx_cycle++;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
                RX_COMB:   m_tready <= ((rx_cycle % 5) < 2);
                default:
                begin
                    // long stretches of stall and of flow
                    if (hold == 0) begin
                        hold = $urandom_range(1, 50);
                        level = ~level;
                    end
                    hold--;
                    m_tready <= level;
                end
            endcase
        end
    end

    // run limit
    initial begin
        #12000000;
        $display("adc_channel_scan_vref_ratiometric test failed");
        $finish;
    end

    initial begin
        sb = new();
        gap_max = 2;
        burst_left = 4;
        rx_mode = RX_RANDOM;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed scans at reset register values
        // idle tick selects the reference, done flag ignored
        send_word(1'b1, 12'hABC);
        // start tick with garbage sample, then a busy tick
        send_word(1'b0, FULL_SCALE);
        send_word(1'b0, FULL_SCALE);
        send_word(1'b1, FULL_SCALE);      // reference full scale
        send_word(1'b1, '0);              // done flag on a start tick is ignored
        send_word(1'b1, FULL_SCALE);      // battery full scale
        send_word(1'b0, '0);
        send_word(1'b1, '0);              // 8 v rail zero
        send_word(1'b0, '0);
        send_word(1'b1, FULL_SCALE);      // 12 v rail full scale
        send_word(1'b0, '0);
        send_word(1'b1, '0);              // temperature zero, closes the scan
        // second scan with a zero reference sample
        send_word(1'b0, '0);
        send_word(1'b1, '0);
        send_word(1'b0, '0);
        send_word(1'b1, 12'd1234);
        send_word(1'b0, '0);
        send_word(1'b1, 12'd2048);
        send_word(1'b0, '0);
        send_word(1'b1, 12'd1);
        send_word(1'b0, '0);
        send_word(1'b1, FULL_SCALE);

        // register extremes, then random settings
        run_setting(1000, 1, 1, 0, 1, 4, RX_RANDOM, WORDS_PER_SETTING);
        run_setting(1300, 15, 31, 2000, 10000, 0, RX_OPEN, WORDS_PER_SETTING);
        // zero slope counts as one microvolt per degree
        run_setting(1300, 7, 20, 900, 0, 6, RX_COMB, WORDS_PER_SETTING);
        run_setting(1200, 4, 11, 750, 2750, 3, RX_LONG, WORDS_PER_SETTING);
        repeat (4) begin
            run_setting($urandom_range(1000, 1300), $urandom_range(1, 15),
                        $urandom_range(1, 31), $urandom_range(0, 2000),
                        $urandom_range(1, 10000), $urandom_range(0, 8),
                        rx_mode_t'($urandom_range(0, 3)), WORDS_PER_SETTING);
        end

        drain_words();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        $display("covered %0d words over %0d register settings", sb.n_words, n_settings + 1);
        $display("%0d scan reports, %0d with zero reference, %0d saturated",
                 sb.n_reports, sb.n_zero_ref, sb.n_saturated);
        if (sb.errors == 0 && sb.words_due.size() == 0)
            $display("adc_channel_scan_vref_ratiometric test passed");
        else
            $display("adc_channel_scan_vref_ratiometric test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/adcscan_pkg.sv
rtl/core/adc_channel_scan_vref_ratiometric.sv
verif/testbench.sv
